>>> rtl/core/ordered_list_insert_delete_macros.svh
// Assertion macros for the ordered list block.
`ifndef ORDERED_LIST_INSERT_DELETE_MACROS_SVH
`define ORDERED_LIST_INSERT_DELETE_MACROS_SVH

`ifndef SYNTHESIS

// Consequent must hold in the same cycle as the antecedent.
`define OLID_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("olid: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define OLID_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("olid: next-cycle check failed");

`else

`define OLID_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define OLID_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

>>> rtl/core/olid_pkg.sv
package olid_pkg;

    localparam int CMD_W    = 3;
    localparam int POS_W    = 6;
    localparam int WORD_W   = 32;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 7;

    localparam logic [CMD_W-1:0] CMD_APPEND = 3'd0;
    localparam logic [CMD_W-1:0] CMD_INSERT = 3'd1;
    localparam logic [CMD_W-1:0] CMD_DELETE = 3'd2;
    localparam logic [CMD_W-1:0] CMD_CLEAR  = 3'd3;
    localparam logic [CMD_W-1:0] CMD_READ   = 3'd4;

    localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
    localparam logic [STATUS_W-1:0] ST_RANGE = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

    // one request
    typedef struct packed {
        logic [CMD_W-1:0]         command;
        logic [POS_W-1:0]         position;
        logic signed [WORD_W-1:0] value;
    } olid_req_t;

    // one response
    typedef struct packed {
        logic [STATUS_W-1:0]      status;
        logic signed [WORD_W-1:0] read_word;
        logic [COUNT_W-1:0]       entry_count;
    } olid_rsp_t;

    // controller to datapath
    typedef struct packed {
        logic capture;
        logic exec;
        logic step;
        logic finish;
        logic load_out;
    } olid_dp_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic need_shift;
        logic shift_last;
    } olid_dp_stat_t;

endpackage

>>> rtl/core/olid_ctrl.sv
module olid_ctrl
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   req_valid,
    output logic                   req_ready,
    output logic                   rsp_valid,
    input  logic                   rsp_ready,
    output olid_pkg::olid_dp_cmd_t dp_cmd,
    input  olid_pkg::olid_dp_stat_t dp_stat
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_EXEC  = 3'd1;
    localparam logic [2:0] S_SHIFT = 3'd2;
    localparam logic [2:0] S_FINAL = 3'd3;
    localparam logic [2:0] S_RESP  = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       rsp_valid_reg;
    logic       rsp_valid_next;

    always_comb
    begin
        dp_cmd.capture  = (state_reg == S_IDLE) && req_valid;
        dp_cmd.exec     = (state_reg == S_EXEC);
        dp_cmd.step     = (state_reg == S_SHIFT);
        dp_cmd.finish   = (state_reg == S_FINAL);
        dp_cmd.load_out = (state_reg == S_RESP) && (!rsp_valid_reg || rsp_ready);
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                state_next = dp_stat.need_shift ? S_SHIFT : S_RESP;
            end
            S_SHIFT:
            begin
                if (dp_stat.shift_last)
                begin
                    state_next = S_FINAL;
                end
            end
            S_FINAL:
            begin
                state_next = S_RESP;
            end
            S_RESP:
            begin
                if (dp_cmd.load_out)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (dp_cmd.load_out)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
        else
        begin
            rsp_valid_next = rsp_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    assign req_ready = (state_reg == S_IDLE);
    assign rsp_valid = rsp_valid_reg;

endmodule

>>> rtl/core/olid_dp.sv
module olid_dp
#(
    parameter int CAPACITY = 64
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  olid_pkg::olid_req_t     req,
    output olid_pkg::olid_rsp_t     rsp,
    input  olid_pkg::olid_dp_cmd_t  dp_cmd,
    output olid_pkg::olid_dp_stat_t dp_stat
);

    localparam int AW   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW   = $clog2(CAPACITY + 1);
    localparam int CMPW = (CW > olid_pkg::POS_W) ? CW : olid_pkg::POS_W;

    localparam logic [CW-1:0]   CAP_C = CW'(CAPACITY);
    localparam logic [CMPW-1:0] CAP_W = CMPW'(CAPACITY);

    // slots at or above the count are never read back: they answer as zero
    logic [olid_pkg::WORD_W-1:0] slots_reg [CAPACITY];
    logic [olid_pkg::WORD_W-1:0] rd_data_reg;

    olid_pkg::olid_req_t         req_reg;
    olid_pkg::olid_rsp_t         rsp_reg;
    logic [CW-1:0]               count_reg;
    logic [CW-1:0]               count_next;
    logic [AW-1:0]               dst_reg;
    logic [AW-1:0]               dst_next;
    logic [olid_pkg::STATUS_W-1:0] res_status_reg;
    logic [olid_pkg::WORD_W-1:0] res_word_reg;

    logic [olid_pkg::STATUS_W-1:0] status_c;
    logic [olid_pkg::WORD_W-1:0] word_c;
    logic [CMPW-1:0]             pos_w;
    logic [CMPW-1:0]             cnt_w;
    logic [AW-1:0]               pos_a;
    logic [AW-1:0]               count_a;
    logic [AW-1:0]               rd_addr;
    logic [AW-1:0]               wr_addr;
    logic [olid_pkg::WORD_W-1:0] wr_data;
    logic                        wr_en;
    logic                        is_app;
    logic                        is_ins;
    logic                        is_del;
    logic                        is_clr;
    logic                        is_rd;
    logic                        full;
    logic                        app_ok;
    logic                        ins_ok;
    logic                        del_ok;
    logic                        ins_at_end;
    logic                        del_at_end;

    assign is_app = (req_reg.command == olid_pkg::CMD_APPEND);
    assign is_ins = (req_reg.command == olid_pkg::CMD_INSERT);
    assign is_del = (req_reg.command == olid_pkg::CMD_DELETE);
    assign is_clr = (req_reg.command == olid_pkg::CMD_CLEAR);
    assign is_rd  = (req_reg.command == olid_pkg::CMD_READ);

    assign pos_w   = CMPW'(req_reg.position);
    assign cnt_w   = CMPW'(count_reg);
    assign pos_a   = AW'(req_reg.position);
    assign count_a = AW'(count_reg);
    assign full    = (count_reg == CAP_C);

    always_comb
    begin
        status_c = olid_pkg::ST_DONE;
        case (req_reg.command)
            olid_pkg::CMD_APPEND:
            begin
                if (full)
                begin
                    status_c = olid_pkg::ST_FULL;
                end
            end
            olid_pkg::CMD_INSERT:
            begin
                if (pos_w > cnt_w)
                begin
                    status_c = olid_pkg::ST_RANGE;
                end
                else if (full)
                begin
                    status_c = olid_pkg::ST_FULL;
                end
            end
            olid_pkg::CMD_DELETE:
            begin
                if (pos_w >= cnt_w)
                begin
                    status_c = olid_pkg::ST_RANGE;
                end
            end
            olid_pkg::CMD_READ:
            begin
                if (pos_w >= CAP_W)
                begin
                    status_c = olid_pkg::ST_RANGE;
                end
            end
            default:
            begin
                status_c = olid_pkg::ST_DONE;
            end
        endcase
    end

    assign word_c = (is_rd && (pos_w < cnt_w)) ? rd_data_reg : '0;

    assign app_ok     = is_app && (status_c == olid_pkg::ST_DONE);
    assign ins_ok     = is_ins && (status_c == olid_pkg::ST_DONE);
    assign del_ok     = is_del && (status_c == olid_pkg::ST_DONE);
    assign ins_at_end = (pos_w == cnt_w);
    assign del_at_end = ((pos_w + CMPW'(1)) == cnt_w);

    assign dp_stat.need_shift = (ins_ok && !ins_at_end) || (del_ok && !del_at_end);
    assign dp_stat.shift_last = is_ins ? (dst_reg == (pos_a + AW'(1)))
                                       : (dst_reg == (count_a - AW'(2)));

    // insert moves words up from the top, delete moves them down from the hole
    always_comb
    begin
        dst_next = dst_reg;
        rd_addr  = dst_reg;
        if (dp_cmd.capture)
        begin
            rd_addr = AW'(req.position);
        end
        else if (dp_cmd.exec)
        begin
            if (is_ins)
            begin
                dst_next = count_a;
                rd_addr  = count_a - AW'(1);
            end
            else
            begin
                dst_next = pos_a;
                rd_addr  = pos_a + AW'(1);
            end
        end
        else if (dp_cmd.step)
        begin
            if (is_ins)
            begin
                dst_next = dst_reg - AW'(1);
                rd_addr  = dst_reg - AW'(2);
            end
            else
            begin
                dst_next = dst_reg + AW'(1);
                rd_addr  = dst_reg + AW'(2);
            end
        end
    end

    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = dst_reg;
        wr_data = rd_data_reg;
        if (dp_cmd.exec && app_ok)
        begin
            wr_en   = 1'b1;
            wr_addr = count_a;
            wr_data = req_reg.value;
        end
        else if (dp_cmd.exec && ins_ok && ins_at_end)
        begin
            wr_en   = 1'b1;
            wr_addr = pos_a;
            wr_data = req_reg.value;
        end
        else if (dp_cmd.step)
        begin
            wr_en = 1'b1;
        end
        else if (dp_cmd.finish && is_ins)
        begin
            wr_en   = 1'b1;
            wr_addr = pos_a;
            wr_data = req_reg.value;
        end
    end

    always_comb
    begin
        count_next = count_reg;
        if (dp_cmd.exec)
        begin
            if (app_ok || (ins_ok && ins_at_end))
            begin
                count_next = count_reg + CW'(1);
            end
            else if (del_ok && del_at_end)
            begin
                count_next = count_reg - CW'(1);
            end
            else if (is_clr)
            begin
                count_next = '0;
            end
        end
        else if (dp_cmd.finish)
        begin
            count_next = is_ins ? (count_reg + CW'(1)) : (count_reg - CW'(1));
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            slots_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= slots_reg[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (dp_cmd.capture)
        begin
            req_reg <= req;
        end
        if (dp_cmd.exec)
        begin
            res_status_reg <= status_c;
            res_word_reg   <= word_c;
        end
        if (dp_cmd.load_out)
        begin
            rsp_reg.status      <= res_status_reg;
            rsp_reg.read_word   <= res_word_reg;
            rsp_reg.entry_count <= olid_pkg::COUNT_W'(count_reg);
        end
        dst_reg <= dst_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    assign rsp = rsp_reg;

endmodule

>>> rtl/core/ordered_list_insert_delete.sv
// Ordered list of signed 32-bit words, held in a single-port-write memory.
// Requests come in on req/req_valid/req_ready: append, insert at a position,
// delete at a position, clear, or read a slot. Each request gives exactly one
// response on rsp/rsp_valid/rsp_ready with status, read word and entry count.
// A request is taken only when the block is idle. Append, clear, read and
// insert/delete at the list end go from the execute state straight to the
// response state. Insert or delete that moves words runs a shift state and
// then a final state in between; the memory moves one word per cycle (read
// one slot, write it one place over). The next request is taken only once
// the response state has returned to idle.
// Reset empties the list at once; no clearing pass is run, since slots at or
// above the count always read back as zero. Clear only resets the count.
// A response waits in the output register while rsp_ready is low; the block
// takes one more request, then holds in its response state until the waiting
// response is passed on.
`include "ordered_list_insert_delete_macros.svh"

module ordered_list_insert_delete
#(
    parameter int CAPACITY = 64
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_ready,
    input  olid_pkg::olid_req_t req,
    output logic                rsp_valid,
    input  logic                rsp_ready,
    output olid_pkg::olid_rsp_t rsp
);

    localparam logic [olid_pkg::COUNT_W-1:0] CAP_LOW = CAPACITY[olid_pkg::COUNT_W-1:0];

    olid_pkg::olid_dp_cmd_t  dp_cmd;
    olid_pkg::olid_dp_stat_t dp_stat;

    olid_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .dp_cmd    (dp_cmd),
        .dp_stat   (dp_stat)
    );

    olid_dp #(.CAPACITY(CAPACITY)) u_dp
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req),
        .rsp     (rsp),
        .dp_cmd  (dp_cmd),
        .dp_stat (dp_stat)
    );

    `OLID_ASSERT_NEXT(a_busy_after_req, clk, rst_n, req_valid && req_ready, !req_ready)
    `OLID_ASSERT_NOW(a_cmd_exclusive, clk, rst_n, 1'b1, $onehot0(dp_cmd))
    `OLID_ASSERT_NOW(a_reject_no_word, clk, rst_n, rsp_valid && (rsp.status != olid_pkg::ST_DONE), rsp.read_word == '0)
    `OLID_ASSERT_NOW(a_full_count, clk, rst_n, rsp_valid && (rsp.status == olid_pkg::ST_FULL), rsp.entry_count == CAP_LOW)

endmodule
